@@ src/tpcd_pkg.sv @@
// Shared constants, request types and field layout for the triangle coverage and depth core.
`timescale 1ns / 1ps
package tpcd_pkg;

	localparam int SUBPIXEL_BITS    = 4;
	localparam int WEIGHT_FRAC_BITS = 16;

	localparam int PIX_W = 11;
	localparam int CRD_W = 16;
	localparam int DEP_W = 24;
	localparam int WGT_W = 20;

	// Scaled pixel position, vertex differences, products and cross products.
	localparam int PXS_W = PIX_W + SUBPIXEL_BITS;
	localparam int DIF_W = ((PXS_W + 1 > CRD_W) ? PXS_W + 1 : CRD_W) + 1;
	localparam int PRD_W = 2 * DIF_W;
	localparam int CRS_W = PRD_W + 1;
	localparam int MAG_W = CRS_W;
	localparam int QUO_W = MAG_W + WEIGHT_FRAC_BITS;
	localparam int QA_W  = QUO_W + 3;
	localparam int DPR_W = WGT_W + DEP_W + 1;
	localparam int DSM_W = DPR_W + 2;

	localparam logic [DEP_W-1:0] DEPTH_MAX = {DEP_W{1'b1}};

	// Stream layout.
	localparam int IN_W       = 2 * PIX_W + 6 * CRD_W + 3 * DEP_W;
	localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W      = 1 + 3 * WGT_W + DEP_W;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 1;

	localparam int OFS_PX = 0;
	localparam int OFS_PY = OFS_PX + PIX_W;
	localparam int OFS_AX = OFS_PY + PIX_W;
	localparam int OFS_AY = OFS_AX + CRD_W;
	localparam int OFS_BX = OFS_AY + CRD_W;
	localparam int OFS_BY = OFS_BX + CRD_W;
	localparam int OFS_CX = OFS_BY + CRD_W;
	localparam int OFS_CY = OFS_CX + CRD_W;
	localparam int OFS_DA = OFS_CY + CRD_W;
	localparam int OFS_DB = OFS_DA + DEP_W;
	localparam int OFS_DC = OFS_DB + DEP_W;

	localparam int OFS_IN  = 0;
	localparam int OFS_WA  = 1;
	localparam int OFS_WB  = OFS_WA + WGT_W;
	localparam int OFS_WC  = OFS_WB + WGT_W;
	localparam int OFS_DEP = OFS_WC + WGT_W;

	typedef struct packed {
		logic        [PIX_W-1:0] px;
		logic        [PIX_W-1:0] py;
		logic signed [CRD_W-1:0] ax;
		logic signed [CRD_W-1:0] ay;
		logic signed [CRD_W-1:0] bx;
		logic signed [CRD_W-1:0] by;
		logic signed [CRD_W-1:0] cx;
		logic signed [CRD_W-1:0] cy;
		logic        [DEP_W-1:0] da;
		logic        [DEP_W-1:0] db;
		logic        [DEP_W-1:0] dc;
	} tri_req_t;

	typedef struct packed {
		logic             covered;
		logic             degen;
		logic             neg_b;
		logic             neg_g;
		logic [DEP_W-1:0] da;
		logic [DEP_W-1:0] db;
		logic [DEP_W-1:0] dc;
	} side_t;

	typedef struct packed {
		logic [MAG_W-1:0] den;
		logic [MAG_W-1:0] rem_b;
		logic [MAG_W-1:0] rem_g;
		logic [QUO_W-1:0] num_b;
		logic [QUO_W-1:0] num_g;
		logic [QUO_W-1:0] q_b;
		logic [QUO_W-1:0] q_g;
		side_t            side;
	} div_t;

	typedef struct packed {
		logic                    covered;
		logic                    degen;
		logic signed [WGT_W-1:0] wa;
		logic signed [WGT_W-1:0] wb;
		logic signed [WGT_W-1:0] wc;
		logic        [DEP_W-1:0] depth;
	} result_t;

endpackage

@@ src/tpcd_setup.sv @@
// Front pipeline: vertex differences, products, edge functions and divider operands.
`timescale 1ns / 1ps
module tpcd_setup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  tpcd_pkg::tri_req_t in_req,
	output logic              out_valid,
	output tpcd_pkg::div_t    out_div
);
	import tpcd_pkg::*;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic signed [DIF_W-1:0] pxs, pys;
	logic signed [DIF_W-1:0] dax_s1, day_s1, dbx_s1, dby_s1, dcx_s1, dcy_s1;
	logic signed [DIF_W-1:0] abx_s1, aby_s1, bcx_s1, bcy_s1, cax_s1, cay_s1;
	logic [3*DEP_W-1:0]      dep_s1, dep_s2, dep_s3;
	logic signed [PRD_W-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2, p7_s2, p8_s2;
	logic signed [PRD_W-1:0] p9_s2, p10_s2;
	logic signed [CRS_W-1:0] e1_s3, e2_s3, e3_s3, den_s3, nb_s3;
	logic                    neg_d, neg_nb, neg_ng;
	logic [MAG_W-1:0]        mag_d, mag_nb, mag_ng;
	logic                    all_le, all_ge;
	div_t                    div_s4;
	div_t                    div_s4_d;

	assign pxs = $signed(DIF_W'(in_req.px) << SUBPIXEL_BITS);
	assign pys = $signed(DIF_W'(in_req.py) << SUBPIXEL_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1 <= DIF_W'(in_req.ax) - pxs;
			day_s1 <= DIF_W'(in_req.ay) - pys;
			dbx_s1 <= DIF_W'(in_req.bx) - pxs;
			dby_s1 <= DIF_W'(in_req.by) - pys;
			dcx_s1 <= DIF_W'(in_req.cx) - pxs;
			dcy_s1 <= DIF_W'(in_req.cy) - pys;
			abx_s1 <= DIF_W'(in_req.bx) - DIF_W'(in_req.ax);
			aby_s1 <= DIF_W'(in_req.by) - DIF_W'(in_req.ay);
			bcx_s1 <= DIF_W'(in_req.cx) - DIF_W'(in_req.bx);
			bcy_s1 <= DIF_W'(in_req.cy) - DIF_W'(in_req.by);
			cax_s1 <= DIF_W'(in_req.ax) - DIF_W'(in_req.cx);
			cay_s1 <= DIF_W'(in_req.ay) - DIF_W'(in_req.cy);
			dep_s1 <= {in_req.da, in_req.db, in_req.dc};

			p1_s2  <= dax_s1 * aby_s1;
			p2_s2  <= abx_s1 * day_s1;
			p3_s2  <= dbx_s1 * bcy_s1;
			p4_s2  <= bcx_s1 * dby_s1;
			p5_s2  <= dcx_s1 * cay_s1;
			p6_s2  <= cax_s1 * dcy_s1;
			p7_s2  <= aby_s1 * cax_s1;
			p8_s2  <= abx_s1 * cay_s1;
			p9_s2  <= dax_s1 * cay_s1;
			p10_s2 <= day_s1 * cax_s1;
			dep_s2 <= dep_s1;

			// The gamma numerator is the same cross product as the first edge function.
			e1_s3  <= CRS_W'(p1_s2) - CRS_W'(p2_s2);
			e2_s3  <= CRS_W'(p3_s2) - CRS_W'(p4_s2);
			e3_s3  <= CRS_W'(p5_s2) - CRS_W'(p6_s2);
			den_s3 <= CRS_W'(p7_s2) - CRS_W'(p8_s2);
			nb_s3  <= CRS_W'(p9_s2) - CRS_W'(p10_s2);
			dep_s3 <= dep_s2;

			div_s4 <= div_s4_d;
		end
	end

	assign neg_d  = den_s3[CRS_W-1];
	assign neg_nb = nb_s3[CRS_W-1];
	assign neg_ng = e1_s3[CRS_W-1];
	assign mag_d  = neg_d  ? MAG_W'(-den_s3) : MAG_W'(den_s3);
	assign mag_nb = neg_nb ? MAG_W'(-nb_s3)  : MAG_W'(nb_s3);
	assign mag_ng = neg_ng ? MAG_W'(-e1_s3)  : MAG_W'(e1_s3);
	assign all_le = (e1_s3 <= 0) && (e2_s3 <= 0) && (e3_s3 <= 0);
	assign all_ge = (e1_s3 >= 0) && (e2_s3 >= 0) && (e3_s3 >= 0);

	always_comb begin
		div_s4_d              = '0;
		div_s4_d.den          = mag_d;
		div_s4_d.num_b        = QUO_W'(mag_nb) << WEIGHT_FRAC_BITS;
		div_s4_d.num_g        = QUO_W'(mag_ng) << WEIGHT_FRAC_BITS;
		div_s4_d.side.covered = all_le || all_ge;
		div_s4_d.side.degen   = (den_s3 == '0);
		div_s4_d.side.neg_b   = neg_nb ^ neg_d;
		div_s4_d.side.neg_g   = neg_ng ^ neg_d;
		div_s4_d.side.da      = dep_s3[3*DEP_W-1:2*DEP_W];
		div_s4_d.side.db      = dep_s3[2*DEP_W-1:DEP_W];
		div_s4_d.side.dc      = dep_s3[DEP_W-1:0];
	end

	assign out_valid = v_s4;
	assign out_div   = div_s4;

endmodule

@@ src/tpcd_div_cell.sv @@
// One restoring division cell: one quotient bit each for the beta and gamma weights.
`timescale 1ns / 1ps
module tpcd_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  tpcd_pkg::div_t in_div,
	output logic           out_valid,
	output tpcd_pkg::div_t out_div
);
	import tpcd_pkg::*;

	logic [MAG_W:0] t_b, t_g, dv, df_b, df_g;
	logic           ge_b, ge_g;
	div_t           nxt;

	assign dv   = {1'b0, in_div.den};
	assign t_b  = {in_div.rem_b, in_div.num_b[QUO_W-1]};
	assign t_g  = {in_div.rem_g, in_div.num_g[QUO_W-1]};
	assign ge_b = (t_b >= dv);
	assign ge_g = (t_g >= dv);
	assign df_b = t_b - dv;
	assign df_g = t_g - dv;

	always_comb begin
		nxt       = in_div;
		nxt.rem_b = ge_b ? df_b[MAG_W-1:0] : t_b[MAG_W-1:0];
		nxt.rem_g = ge_g ? df_g[MAG_W-1:0] : t_g[MAG_W-1:0];
		nxt.num_b = {in_div.num_b[QUO_W-2:0], 1'b0};
		nxt.num_g = {in_div.num_g[QUO_W-2:0], 1'b0};
		nxt.q_b   = {in_div.q_b[QUO_W-2:0], ge_b};
		nxt.q_g   = {in_div.q_g[QUO_W-2:0], ge_g};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_div <= nxt;
		end
	end

endmodule

@@ src/tpcd_post.sv @@
// Back pipeline: signed weights, saturation, depth products and depth clamp.
`timescale 1ns / 1ps
module tpcd_post (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  tpcd_pkg::div_t    in_div,
	output logic              out_valid,
	output tpcd_pkg::result_t out_res
);
	import tpcd_pkg::*;

	localparam logic signed [QA_W-1:0] ONE  = QA_W'(1) << WEIGHT_FRAC_BITS;
	localparam logic signed [QA_W-1:0] WMAX = QA_W'((1 << (WGT_W - 1)) - 1);
	localparam logic signed [QA_W-1:0] WMIN = -QA_W'(1 << (WGT_W - 1));

	function automatic logic signed [WGT_W-1:0] sat_w(input logic signed [QA_W-1:0] v);
		if (v > WMAX) begin
			return WMAX[WGT_W-1:0];
		end else if (v < WMIN) begin
			return WMIN[WGT_W-1:0];
		end
		return v[WGT_W-1:0];
	endfunction

	logic                    v_s1, v_s2, v_s3;
	logic signed [QA_W-1:0]  qb, qg, qa;
	logic signed [WGT_W-1:0] wa_s1, wb_s1, wc_s1;
	logic signed [WGT_W-1:0] wa_s2, wb_s2, wc_s2;
	logic [DEP_W-1:0]        da_s1, db_s1, dc_s1;
	logic                    ins_s1, ins_s2, dg_s1, dg_s2;
	logic signed [DPR_W-1:0] ma_s2, mb_s2, mc_s2;
	logic signed [DSM_W-1:0] sum;
	logic signed [DSM_W-1:0] shf;
	result_t                 res_s3;

	assign qb = in_div.side.neg_b ? -QA_W'({1'b0, in_div.q_b}) : QA_W'({1'b0, in_div.q_b});
	assign qg = in_div.side.neg_g ? -QA_W'({1'b0, in_div.q_g}) : QA_W'({1'b0, in_div.q_g});
	assign qa = ONE - qb - qg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sum = DSM_W'(ma_s2) + DSM_W'(mb_s2) + DSM_W'(mc_s2);
	assign shf = sum >>> WEIGHT_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			// A flat triangle forces zero weights, which in turn give zero depth.
			wa_s1  <= in_div.side.degen ? '0 : sat_w(qa);
			wb_s1  <= in_div.side.degen ? '0 : sat_w(qb);
			wc_s1  <= in_div.side.degen ? '0 : sat_w(qg);
			da_s1  <= in_div.side.da;
			db_s1  <= in_div.side.db;
			dc_s1  <= in_div.side.dc;
			ins_s1 <= in_div.side.covered;
			dg_s1  <= in_div.side.degen;

			ma_s2  <= wa_s1 * $signed({1'b0, da_s1});
			mb_s2  <= wb_s1 * $signed({1'b0, db_s1});
			mc_s2  <= wc_s1 * $signed({1'b0, dc_s1});
			wa_s2  <= wa_s1;
			wb_s2  <= wb_s1;
			wc_s2  <= wc_s1;
			ins_s2 <= ins_s1;
			dg_s2  <= dg_s1;

			res_s3.covered <= ins_s2;
			res_s3.degen   <= dg_s2;
			res_s3.wa      <= wa_s2;
			res_s3.wb      <= wb_s2;
			res_s3.wc      <= wc_s2;
			if (sum < 0) begin
				res_s3.depth <= '0;
			end else if (shf > $signed(DSM_W'(DEPTH_MAX))) begin
				res_s3.depth <= DEPTH_MAX;
			end else begin
				res_s3.depth <= shf[DEP_W-1:0];
			end
		end
	end

	assign out_valid = v_s3;
	assign out_res   = res_s3;

endmodule

@@ src/triangle_pixel_coverage_depth_core.sv @@
// Triangle pixel coverage and barycentric depth core: top level with divider cell chain.
// Stages: 4 setup, 51 divider cells (one quotient bit each), 3 post, 1 output register.
// Throughput: one request per cycle while the skid buffer is empty.
// Reset: arst_n clears every valid flag and the skid buffer; payload registers are not reset.
`timescale 1ns / 1ps
module triangle_pixel_coverage_depth_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pixel_x, pixel_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
	// vertex_c_x, vertex_c_y, depth_a, depth_b, depth_c, zero fill
	input  logic [tpcd_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// inside_res, weight_alpha, weight_beta, weight_gamma, depth_out, zero fill
	output logic [tpcd_pkg::OUT_DATA_W-1:0]     m_tdata,
	// degenerate
	output logic [tpcd_pkg::OUT_USER_W-1:0]     m_tuser
);
	import tpcd_pkg::*;

	// The whole pipeline moves together while the skid buffer is empty. The
	// output register can hold a finished result while the pipeline still
	// advances; a result that arrives behind a stalled one lands in the skid
	// buffer, and only then does the pipeline stop taking requests.
	logic     en;
	tri_req_t req;
	logic     cv [QUO_W+1];
	div_t     cd [QUO_W+1];
	logic     fin_valid;
	result_t  fin_res;
	logic     out_valid_q, skid_valid_q;
	result_t  out_q, skid_q;

	assign en       = !skid_valid_q;
	assign s_tready = en;

	assign req.px = s_tdata[OFS_PX +: PIX_W];
	assign req.py = s_tdata[OFS_PY +: PIX_W];
	assign req.ax = $signed(s_tdata[OFS_AX +: CRD_W]);
	assign req.ay = $signed(s_tdata[OFS_AY +: CRD_W]);
	assign req.bx = $signed(s_tdata[OFS_BX +: CRD_W]);
	assign req.by = $signed(s_tdata[OFS_BY +: CRD_W]);
	assign req.cx = $signed(s_tdata[OFS_CX +: CRD_W]);
	assign req.cy = $signed(s_tdata[OFS_CY +: CRD_W]);
	assign req.da = s_tdata[OFS_DA +: DEP_W];
	assign req.db = s_tdata[OFS_DB +: DEP_W];
	assign req.dc = s_tdata[OFS_DC +: DEP_W];

	// Edge functions, cross products and the unsigned divider operands.
	tpcd_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_req    (req),
		.out_valid (cv[0]),
		.out_div   (cd[0])
	);

	// Each cell resolves one quotient bit, most significant first, for both
	// weights, and hands its partial remainders on to the next cell.
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		tpcd_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cv[i]),
			.in_div    (cd[i]),
			.out_valid (cv[i+1]),
			.out_div   (cd[i+1])
		);
	end

	// Sign restore, alpha, saturation and the depth blend.
	tpcd_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv[QUO_W]),
		.in_div    (cd[QUO_W]),
		.out_valid (fin_valid),
		.out_res   (fin_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= fin_valid;
			end
		end else if (fin_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : fin_res;
		end else if (en && fin_valid) begin
			skid_q <= fin_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = OUT_USER_W'(out_q.degen);
	always_comb begin
		m_tdata                    = '0;
		m_tdata[OFS_IN]            = out_q.covered;
		m_tdata[OFS_WA +: WGT_W]   = out_q.wa;
		m_tdata[OFS_WB +: WGT_W]   = out_q.wb;
		m_tdata[OFS_WC +: WGT_W]   = out_q.wc;
		m_tdata[OFS_DEP +: DEP_W]  = out_q.depth;
	end

`ifndef SYNTH
	// The skid buffer only fills behind a result that is already on show.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid buffer holds a result while the output is empty");

	// A flat triangle carries zero weights and zero depth.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (out_q.wa == '0 && out_q.wb == '0 &&
		out_q.wc == '0 && out_q.depth == '0))
		else $error("degenerate result with non-zero weights or depth");

	// A stalled pipeline must not move: the last divider cell holds its request.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cv[QUO_W]))
		else $error("divider chain advanced while stalled");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the triangle pixel coverage and barycentric depth core.
`timescale 1ns / 1ps
module tb;
	import tpcd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int N_RANDOM     = 1032;
	localparam int MAX_REPORTS  = 10;

	// The scoreboard predicts the coverage, weights and depth of each accepted request
	// and holds them in arrival order until the block returns its result.
	class coverage_scoreboard;
		result_t pending_results[$];
		int      mismatches;

		function new();
			mismatches = 0;
		endfunction

		function automatic longint clamp_weight(longint v);
			longint hi;
			longint lo;
			hi = (longint'(1) << (WGT_W - 1)) - 1;
			lo = -(longint'(1) << (WGT_W - 1));
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function automatic longint edge_value(longint px, longint py, longint ux, longint uy,
			longint vx, longint vy);
			return (ux - px) * (vy - uy) - (vx - ux) * (uy - py);
		endfunction

		function automatic result_t shade_pixel(tri_req_t r);
			longint px, py, ax, ay, bx, by, cx, cy;
			longint e1, e2, e3, den, nb, ng, qb, qg, qa, wa, wb, wc, acc, dep, one;
			result_t res;
			px  = longint'(r.px) <<< SUBPIXEL_BITS;
			py  = longint'(r.py) <<< SUBPIXEL_BITS;
			ax  = longint'(r.ax);
			ay  = longint'(r.ay);
			bx  = longint'(r.bx);
			by  = longint'(r.by);
			cx  = longint'(r.cx);
			cy  = longint'(r.cy);
			one = longint'(1) << WEIGHT_FRAC_BITS;
			e1  = edge_value(px, py, ax, ay, bx, by);
			e2  = edge_value(px, py, bx, by, cx, cy);
			e3  = edge_value(px, py, cx, cy, ax, ay);
			res = '0;
			res.covered = (e1 <= 0 && e2 <= 0 && e3 <= 0) || (e1 >= 0 && e2 >= 0 && e3 >= 0);
			den = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
			if (den == 0) begin
				res.degen = 1'b1;
				return res;
			end
			nb = (px - ax) * (cy - ay) - (py - ay) * (cx - ax);
			ng = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
			// Signed longint division truncates toward zero, as the weights require.
			qb = (nb * one) / den;
			qg = (ng * one) / den;
			qa = one - qb - qg;
			wa = clamp_weight(qa);
			wb = clamp_weight(qb);
			wc = clamp_weight(qg);
			acc = wa * longint'(r.da) + wb * longint'(r.db) + wc * longint'(r.dc);
			if (acc < 0)
				dep = 0;
			else begin
				dep = acc >>> WEIGHT_FRAC_BITS;
				if (dep > longint'(DEPTH_MAX)) dep = longint'(DEPTH_MAX);
			end
			res.wa    = wa[WGT_W-1:0];
			res.wb    = wb[WGT_W-1:0];
			res.wc    = wc[WGT_W-1:0];
			res.depth = dep[DEP_W-1:0];
			return res;
		endfunction

		function void note_request(tri_req_t r);
			pending_results.push_back(shade_pixel(r));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected result with nothing outstanding: %p", got);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Result mismatch: expected %p, actual %p", want, got);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;

	coverage_scoreboard sb = new();
	int unsigned        send_idle_pct = 0;
	int unsigned        recv_idle_pct = 0;
	int unsigned        cycle_count = 0;

	triangle_pixel_coverage_depth_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver stalls at random; the percentage is changed per phase of the run.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Results are sampled mid-cycle, when everything driven at the rising edge has settled;
	// the handshake then completes at the next rising edge.
	always @(negedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got         = '0;
			got.covered = m_tdata[OFS_IN];
			got.degen   = m_tuser[0];
			got.wa      = m_tdata[OFS_WA +: WGT_W];
			got.wb      = m_tdata[OFS_WB +: WGT_W];
			got.wc      = m_tdata[OFS_WC +: WGT_W];
			got.depth   = m_tdata[OFS_DEP +: DEP_W];
			sb.check_result(got);
		end
	end

	// A hung block must not keep the run going for ever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it. Valid stays high
	// between back-to-back requests, so it is only lowered when the sender idles.
	task automatic send_request(tri_req_t r);
		logic [IN_DATA_W-1:0] word;
		word = '0;
		word[OFS_PX +: PIX_W] = r.px;
		word[OFS_PY +: PIX_W] = r.py;
		word[OFS_AX +: CRD_W] = r.ax;
		word[OFS_AY +: CRD_W] = r.ay;
		word[OFS_BX +: CRD_W] = r.bx;
		word[OFS_BY +: CRD_W] = r.by;
		word[OFS_CX +: CRD_W] = r.cx;
		word[OFS_CY +: CRD_W] = r.cy;
		word[OFS_DA +: DEP_W] = r.da;
		word[OFS_DB +: DEP_W] = r.db;
		word[OFS_DC +: DEP_W] = r.dc;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		sb.note_request(r);
	endtask

	function automatic tri_req_t make_tri(int px, int py, int ax, int ay, int bx, int by,
		int cx, int cy, int da, int db, int dc);
		tri_req_t r;
		r.px = px[PIX_W-1:0];
		r.py = py[PIX_W-1:0];
		r.ax = ax[CRD_W-1:0];
		r.ay = ay[CRD_W-1:0];
		r.bx = bx[CRD_W-1:0];
		r.by = by[CRD_W-1:0];
		r.cx = cx[CRD_W-1:0];
		r.cy = cy[CRD_W-1:0];
		r.da = da[DEP_W-1:0];
		r.db = db[DEP_W-1:0];
		r.dc = dc[DEP_W-1:0];
		return r;
	endfunction

	// A vertex coordinate close to the pixel, clamped to the signed coordinate range.
	function automatic int near_coord(int centre, int spread);
		int v;
		v = centre + $urandom_range(2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	function automatic int rand_depth();
		case ($urandom_range(7))
			0:       return 0;
			1:       return int'(DEPTH_MAX);
			default: return $urandom_range(int'(DEPTH_MAX));
		endcase
	endfunction

	// Most triangles are built around the pixel so that inside, edge and outside cases all
	// occur; the rest are wholly random fields, or collinear vertices for the degenerate path.
	function automatic tri_req_t random_tri();
		tri_req_t r;
		int px, py, cxp, cyp, spread, k;
		int ax, ay, bx, by;
		px  = $urandom_range(2047);
		py  = $urandom_range(2047);
		cxp = px * 16;
		cyp = py * 16;
		spread = ($urandom_range(3) == 0) ? 16000 : ($urandom_range(1) ? 40 : 600);
		case ($urandom_range(9))
			0, 1: begin
				r = tri_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom});
			end
			2: begin
				ax = near_coord(cxp, spread);
				ay = near_coord(cyp, spread);
				bx = near_coord(cxp, spread);
				by = near_coord(cyp, spread);
				k  = $urandom_range(3);
				r  = make_tri(px, py, ax, ay, bx, by, ax + k * (bx - ax), ay + k * (by - ay),
					rand_depth(), rand_depth(), rand_depth());
				if (k == 3) begin
					r.cx = ax[CRD_W-1:0];
					r.cy = ay[CRD_W-1:0];
				end
			end
			default: begin
				r = make_tri(px, py, near_coord(cxp, spread), near_coord(cyp, spread),
					near_coord(cxp, spread), near_coord(cyp, spread),
					near_coord(cxp, spread), near_coord(cyp, spread),
					rand_depth(), rand_depth(), rand_depth());
			end
		endcase
		return r;
	endfunction

	initial begin
		tri_req_t directed[$];
		int       phase;
		int       i;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: both windings, a pixel on a vertex and on an edge, a pixel
		// outside, coincident and collinear vertices, extreme coordinates and depths.
		directed.push_back(make_tri(10, 10, 0, 0, 480, 0, 0, 480, 1000, 2000, 3000));
		directed.push_back(make_tri(10, 10, 0, 0, 0, 480, 480, 0, 1000, 2000, 3000));
		directed.push_back(make_tri(0, 0, 0, 0, 160, 0, 0, 160, 16777215, 0, 0));
		directed.push_back(make_tri(5, 0, 0, 0, 160, 0, 0, 160, 0, 16777215, 0));
		directed.push_back(make_tri(2047, 2047, 0, 0, 160, 0, 0, 160, 5, 6, 7));
		directed.push_back(make_tri(3, 3, 48, 48, 48, 48, 48, 48, 100, 200, 300));
		directed.push_back(make_tri(3, 3, 0, 0, 32, 32, 96, 96, 100, 200, 300));
		directed.push_back(make_tri(4, 3, 0, 0, 32, 32, 96, 96, 100, 200, 300));
		directed.push_back(make_tri(2047, 0, -32768, -32768, 32767, -32768, -32768, 32767,
			16777215, 16777215, 16777215));
		directed.push_back(make_tri(0, 2047, 32767, 32767, -32768, 32767, 32767, -32768,
			0, 0, 0));
		directed.push_back(make_tri(2047, 2047, 0, 0, 1, 0, 0, 1, 16777215, 16777215, 0));
		directed.push_back(make_tri(0, 0, 32767, 32767, 32766, 32767, 32767, 32766,
			16777215, 0, 16777215));
		directed.push_back(make_tri(1024, 1024, 16384, 16380, 16390, 16384, 16384, 16390,
			8388608, 4194304, 12582912));
		directed.push_back(make_tri(1, 1, -32768, 0, 32767, 0, 0, 1, 16777215, 16777215,
			16777215));
		directed.push_back(make_tri(100, 100, 1600, 1600, 1616, 1600, 1600, 1616, 0, 0, 0));
		directed.push_back(make_tri(0, 0, -1, -1, -1, -1, -32768, -32768, 1, 2, 3));
		foreach (directed[j]) send_request(directed[j]);

		// Random requests over three pacing phases: a slow receiver, a slow sender, then
		// both sides running flat out.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 33; recv_idle_pct = 81; end
				1: begin send_idle_pct = 81; recv_idle_pct = 33; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (i = 0; i < N_RANDOM / 3; i++) send_request(random_tri());
		end
		s_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
